### design/vse_pkg.sv
// Package for the value set engine: sizes, request and result types,
// operation codes, controller states and the controller/datapath bundles.
// No dependencies.
package vse_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int KEY_IN_W    = 32;
  localparam int KEY_COUNT_W = 5;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    MODE_CONTAINS = 2'd0,
    MODE_ADD      = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_DUMP     = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [KEY_IN_W-1:0] key_value;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic                   full_reject;
    logic [KEY_COUNT_W-1:0] key_count;
    logic [KEY_IN_W-1:0]    dump_key;
    logic                   dump_valid;
    logic                   last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic load_req;
    logic apply;
    logic idx_clear;
    logic dump_emit;
  } cmd_t;

  typedef struct packed {
    logic is_dump;
    logic set_empty;
    logic dump_final;
  } sts_t;

endpackage

### design/value_set_engine_unit.sv
// Value set engine top level: a packed table of distinct keys with a count.
// Contains, add, remove and a dump of an empty set register their result in the
// UPDATE state once the output is free; no new request is accepted until the
// engine is back in IDLE. A dump of N keys registers one key per cycle in DUMP
// while the output is free. A result the receiver has not taken holds the next one.
// Synchronous reset empties the set without clearing the table. Uses vse_pkg.
module value_set_engine_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  vse_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output vse_pkg::res_t res
);

  vse_pkg::cmd_t cmd;
  vse_pkg::sts_t sts;

  vse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vse_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

### design/vse_ctrl.sv
// Controller state machine of the value set engine.
// Depends on vse_pkg; drives the datapath through cmd_t and reads sts_t.
module vse_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          res_valid,
  input  logic          res_ready,
  output vse_pkg::cmd_t cmd,
  input  vse_pkg::sts_t sts
);

  vse_pkg::state_t state;
  vse_pkg::state_t state_next;
  logic            out_valid;
  logic            out_valid_next;
  logic            out_free;

  assign out_free  = !out_valid || res_ready;
  assign req_ready = (state == vse_pkg::ST_IDLE);
  assign res_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vse_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      vse_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = vse_pkg::ST_UPDATE;
        end
      end
      vse_pkg::ST_UPDATE: begin
        if (sts.is_dump && !sts.set_empty) begin
          cmd.idx_clear = 1'b1;
          state_next    = vse_pkg::ST_DUMP;
        end else if (out_free) begin
          cmd.apply  = 1'b1;
          state_next = vse_pkg::ST_IDLE;
        end
      end
      vse_pkg::ST_DUMP: begin
        if (out_free) begin
          cmd.dump_emit = 1'b1;
          if (sts.dump_final) begin
            state_next = vse_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = vse_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.apply || cmd.dump_emit) begin
      out_valid_next = 1'b1;
    end else if (res_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

### design/vse_datapath.sv
// Datapath of the value set engine: key table, count, lane compares,
// compaction shift, dump index and the result register.
// Depends on vse_pkg; commanded by vse_ctrl.
module vse_datapath (
  input  logic          clk,
  input  logic          rst,
  input  vse_pkg::req_t req,
  output vse_pkg::res_t res,
  input  vse_pkg::cmd_t cmd,
  output vse_pkg::sts_t sts
);

  logic [vse_pkg::KEY_WIDTH-1:0] entries [vse_pkg::CAPACITY];
  logic [vse_pkg::CNT_W-1:0]     count;
  logic [vse_pkg::CNT_W-1:0]     count_next;
  logic [vse_pkg::IDX_W-1:0]     idx;
  vse_pkg::mode_t                mode_q;
  logic [vse_pkg::KEY_WIDTH-1:0] key_q;
  logic [vse_pkg::CAPACITY-1:0]  hit;
  logic [vse_pkg::CAPACITY-1:0]  hit_q;
  logic [vse_pkg::IDX_W-1:0]     pos;
  logic                          found;
  logic                          is_full;
  logic                          add_ok;
  logic                          rem_ok;
  logic                          reject;
  logic [vse_pkg::KEY_WIDTH-1:0] key_in;
  vse_pkg::res_t                 res_next;

  assign key_in = vse_pkg::KEY_WIDTH'(req.key_value);

  always_comb begin
    for (int i = 0; i < vse_pkg::CAPACITY; i++) begin
      hit[i] = (vse_pkg::CNT_W'(i) < count) && (entries[i] == key_in);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < vse_pkg::CAPACITY; i++) begin
      pos = pos | (hit_q[i] ? vse_pkg::IDX_W'(i) : '0);
    end
  end

  assign found   = |hit_q;
  assign is_full = (count >= vse_pkg::CNT_W'(vse_pkg::CAPACITY));
  assign add_ok  = (mode_q == vse_pkg::MODE_ADD) && !found && !is_full;
  assign reject  = (mode_q == vse_pkg::MODE_ADD) && !found && is_full;
  assign rem_ok  = (mode_q == vse_pkg::MODE_REMOVE) && found;

  always_comb begin
    if (add_ok) begin
      count_next = count + 1'b1;
    end else if (rem_ok) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      mode_q <= req.mode;
      key_q  <= key_in;
      hit_q  <= hit;
    end
  end

  for (genvar g = 0; g < vse_pkg::CAPACITY; g++) begin : g_lane
    if (g < vse_pkg::CAPACITY - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (cmd.apply) begin
          if (add_ok && (vse_pkg::CNT_W'(g) == count)) begin
            entries[g] <= key_q;
          end else if (rem_ok && (vse_pkg::IDX_W'(g) >= pos)) begin
            entries[g] <= entries[g+1];
          end
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.apply && add_ok && (vse_pkg::CNT_W'(g) == count)) begin
          entries[g] <= key_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.dump_emit) begin
      idx <= idx + 1'b1;
    end
  end

  assign sts.is_dump    = (mode_q == vse_pkg::MODE_DUMP);
  assign sts.set_empty  = (count == '0);
  assign sts.dump_final = ((vse_pkg::CNT_W'(idx) + 1'b1) == count);

  always_comb begin
    res_next = '0;
    if (cmd.dump_emit) begin
      res_next.key_count  = vse_pkg::KEY_COUNT_W'(count);
      res_next.dump_key   = vse_pkg::KEY_IN_W'(entries[idx]);
      res_next.dump_valid = 1'b1;
      res_next.last       = sts.dump_final;
    end else begin
      res_next.found       = found && !sts.is_dump;
      res_next.full_reject = reject;
      res_next.key_count   = vse_pkg::KEY_COUNT_W'(count_next);
      res_next.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply || cmd.dump_emit) begin
      res <= res_next;
    end
  end

endmodule

### test/value_set_engine_checker.sv
`timescale 1ns / 1ps
// Checker for the value set engine: watches both channels, keeps a shadow copy
// of the key table and compares each result, field by field, in order.
// Depends on vse_pkg.
module value_set_engine_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  vse_pkg::req_t req,
  input  logic          res_valid,
  input  logic          res_ready,
  input  vse_pkg::res_t res,
  output int            fail_count,
  output int            pending_results
);

  localparam logic [vse_pkg::KEY_IN_W-1:0] KEY_MASK =
    {vse_pkg::KEY_IN_W{1'b1}} >> ((vse_pkg::KEY_WIDTH >= vse_pkg::KEY_IN_W) ?
                                  0 : vse_pkg::KEY_IN_W - vse_pkg::KEY_WIDTH);

  logic [vse_pkg::KEY_IN_W-1:0] shadow_keys [vse_pkg::CAPACITY];
  int                           shadow_count;
  vse_pkg::res_t                pending_outcomes [$];

  assign pending_results = pending_outcomes.size();

  task automatic report_mismatch(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    fail_count++;
  endtask

  task automatic enqueue_outcome(input vse_pkg::res_t outcome);
    pending_outcomes = {pending_outcomes, outcome};
  endtask

  task automatic apply_set_op(input vse_pkg::req_t r);
    logic [vse_pkg::KEY_IN_W-1:0] key;
    vse_pkg::res_t                outcome;
    int                           hit;
    key     = r.key_value & KEY_MASK;
    outcome = '0;
    outcome.last = 1'b1;
    if (r.mode == vse_pkg::MODE_DUMP) begin
      if (shadow_count == 0) begin
        enqueue_outcome(outcome);
      end else begin
        for (int i = 0; i < shadow_count; i++) begin
          outcome.key_count  = vse_pkg::KEY_COUNT_W'(shadow_count);
          outcome.dump_key   = shadow_keys[i];
          outcome.dump_valid = 1'b1;
          outcome.last       = (i == shadow_count - 1);
          enqueue_outcome(outcome);
        end
      end
    end else begin
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
        if (hit < 0 && shadow_keys[i] == key) begin
          hit = i;
        end
      end
      if (r.mode == vse_pkg::MODE_ADD && hit < 0) begin
        if (shadow_count >= vse_pkg::CAPACITY) begin
          outcome.full_reject = 1'b1;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_count++;
        end
      end else if (r.mode == vse_pkg::MODE_REMOVE && hit >= 0) begin
        for (int i = hit; i < shadow_count - 1; i++) begin
          shadow_keys[i] = shadow_keys[i + 1];
        end
        shadow_count--;
      end
      outcome.found     = (hit >= 0);
      outcome.key_count = vse_pkg::KEY_COUNT_W'(shadow_count);
      enqueue_outcome(outcome);
    end
  endtask

  task automatic compare_field(input string name,
                               input logic [vse_pkg::KEY_IN_W-1:0] got,
                               input logic [vse_pkg::KEY_IN_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic check_result(input vse_pkg::res_t got);
    vse_pkg::res_t want;
    want = pending_outcomes.pop_front();
    compare_field("found", vse_pkg::KEY_IN_W'(got.found), vse_pkg::KEY_IN_W'(want.found));
    compare_field("full_reject", vse_pkg::KEY_IN_W'(got.full_reject),
                  vse_pkg::KEY_IN_W'(want.full_reject));
    compare_field("key_count", vse_pkg::KEY_IN_W'(got.key_count),
                  vse_pkg::KEY_IN_W'(want.key_count));
    compare_field("dump_key", got.dump_key, want.dump_key);
    compare_field("dump_valid", vse_pkg::KEY_IN_W'(got.dump_valid),
                  vse_pkg::KEY_IN_W'(want.dump_valid));
    compare_field("last", vse_pkg::KEY_IN_W'(got.last), vse_pkg::KEY_IN_W'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_outcomes.delete();
      shadow_count = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("result %0h arrived with none outstanding", res));
        end else begin
          check_result(res);
        end
      end
      if (req_valid && req_ready) begin
        apply_set_op(req);
      end
    end
  end

endmodule

### test/tb_value_set_engine_unit.sv
`timescale 1ns / 1ps
// Testbench top for the value set engine: drives directed and random requests
// under several idle and stall mixes and reports the verdict.
// Depends on vse_pkg, value_set_engine_unit and value_set_engine_checker.
module tb_value_set_engine_unit;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          res_ready = 1'b0;
  logic          req_ready;
  logic          res_valid;
  vse_pkg::req_t req       = '0;
  vse_pkg::res_t res;

  int fail_count;
  int pending_results;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int add_pct        = 50;

  logic [vse_pkg::KEY_IN_W-1:0] key_pool [20];

  value_set_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  value_set_engine_checker set_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(input vse_pkg::mode_t op,
                              input logic [vse_pkg::KEY_IN_W-1:0] key);
    vse_pkg::req_t item;
    item.mode      = op;
    item.key_value = key;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_request();
    int                           pick;
    vse_pkg::mode_t               op;
    logic [vse_pkg::KEY_IN_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 10) op = vse_pkg::MODE_DUMP;
    else if (pick < 30) op = vse_pkg::MODE_CONTAINS;
    else if (pick < 30 + add_pct) op = vse_pkg::MODE_ADD;
    else op = vse_pkg::MODE_REMOVE;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(19)];
    else key = $urandom;
    send_request(op, key);
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 20; i++) key_pool[i] = $urandom;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    send_request(vse_pkg::MODE_DUMP, 32'h1234_5678);
    send_request(vse_pkg::MODE_CONTAINS, 32'h0000_0000);
    send_request(vse_pkg::MODE_REMOVE, 32'hFFFF_FFFF);
    send_request(vse_pkg::MODE_ADD, 32'h0000_0000);
    send_request(vse_pkg::MODE_ADD, 32'hFFFF_FFFF);
    send_request(vse_pkg::MODE_ADD, 32'h0000_0000);
    send_request(vse_pkg::MODE_CONTAINS, 32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) begin
      send_request(vse_pkg::MODE_ADD, (32'h8000_0000 >> i) | i);
    end
    send_request(vse_pkg::MODE_ADD, 32'hA5A5_5A5A);
    send_request(vse_pkg::MODE_DUMP, 32'hFFFF_FFFF);
    send_request(vse_pkg::MODE_REMOVE, 32'h0000_0000);
    send_request(vse_pkg::MODE_REMOVE, 32'h0004_000D);
    send_request(vse_pkg::MODE_DUMP, 32'h0000_0000);
    wait_for_drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;  add_pct = 50;
        end
        1: begin
          send_idle_pct = 49; recv_stall_pct = 0;  add_pct = 20;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 49; add_pct = 45;
        end
        default: begin
          send_idle_pct = 37; recv_stall_pct = 37; add_pct = 35;
        end
      endcase
      for (int n = 0; n < 24; n++) send_random_request();
      wait_for_drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("value_set_engine_unit verification clean");
    end else begin
      $display("value_set_engine_unit verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("value_set_engine_unit verification failed");
    $finish;
  end

endmodule

### files.f
design/vse_pkg.sv
design/vse_ctrl.sv
design/vse_datapath.sv
design/value_set_engine_unit.sv
test/value_set_engine_checker.sv
test/tb_value_set_engine_unit.sv
